@@ rtl/isfd_pkg.sv @@
// Shared types, constants and a helper function of the serial frame deframer.
package isfd_pkg;

	localparam int unsigned STORE_DEPTH = 64;
	localparam int unsigned STORE_AW = $clog2(STORE_DEPTH);
	localparam int unsigned PAYLOAD_START = 7;
	localparam int unsigned MAX_LEN = 127;

	localparam int unsigned FULL_FRAME_BYTES_DEF = 64;
	localparam int unsigned ACCEL_FRAME_BYTES_DEF = 24;
	localparam int unsigned ATTITUDE_FRAME_BYTES_DEF = 56;

	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned REG_IDX_W = 4;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] kind_t;
	typedef logic [3:0] widx_t;

	localparam kind_t KIND_FULL = 2'd0;
	localparam kind_t KIND_ACCEL = 2'd1;
	localparam kind_t KIND_ATT = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_HEAD = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_END = 4'd1;
	localparam logic [REG_IDX_W-1:0] REG_TYPE_FULL = 4'd2;
	localparam logic [REG_IDX_W-1:0] REG_TYPE_ACCEL = 4'd3;
	localparam logic [REG_IDX_W-1:0] REG_TYPE_ATT = 4'd4;
	localparam logic [REG_IDX_W-1:0] REG_LEN_FULL = 4'd5;
	localparam logic [REG_IDX_W-1:0] REG_LEN_ACCEL = 4'd6;
	localparam logic [REG_IDX_W-1:0] REG_LEN_ATT = 4'd7;

	localparam byte_t REG_RESET [NUM_REGS] = '{
		8'd252, 8'd253, 8'd64, 8'd66, 8'd65, 8'd56, 8'd16, 8'd48
	};

	function automatic widx_t words_of_kind(input kind_t kind);
		widx_t n;
		unique case (kind)
			KIND_ACCEL: n = 4'd4;
			KIND_ATT:   n = 4'd11;
			default:    n = 4'd13;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/imu_serial_frame_deframer_core.sv @@
// Top level of the serial frame deframer: byte intake, frame store, check and word output.
//
// Bytes from the serial link enter on the s_t* channel, one beat per byte.
// The user must write configuration registers on the cfg_* channel only while
// the block is idle; the block itself does not enforce this. cfg_ready is always
// high and an index above 7 is ignored.
// A byte that does not complete a frame leaves s_tready high for the next beat.
// The byte that completes a frame starts a check sequence on the single
// read port of the 64-byte frame store: type byte, length byte and end
// marker are read and compared one per cycle through one comparator.
// A bad frame then returns to idle.
// A good frame is read out word by word: each 32-bit word is built from byte
// reads and shifts, then waits in the output register until taken on the m_t*
// channel. The input stays closed until the last word of the frame is taken.
// While the receiver stalls, the output beat holds and s_tready stays low.
// Reset clears the byte history, count, kind and output valid, and loads
// the register defaults; the frame store is not cleared.
module imu_serial_frame_deframer_core #(
	parameter int unsigned FULL_FRAME_BYTES = isfd_pkg::FULL_FRAME_BYTES_DEF,
	parameter int unsigned ACCEL_FRAME_BYTES = isfd_pkg::ACCEL_FRAME_BYTES_DEF,
	parameter int unsigned ATTITUDE_FRAME_BYTES = isfd_pkg::ATTITUDE_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // word_index[3:0], payload_word[35:4], zero fill
	output logic [1:0]  m_tuser,   // frame_kind
	output logic        m_tlast    // last_word
);

	localparam logic [6:0] FULL_LEN =
		7'((FULL_FRAME_BYTES > isfd_pkg::MAX_LEN) ? isfd_pkg::MAX_LEN : FULL_FRAME_BYTES);
	localparam logic [6:0] ACCEL_LEN =
		7'((ACCEL_FRAME_BYTES > isfd_pkg::MAX_LEN) ? isfd_pkg::MAX_LEN : ACCEL_FRAME_BYTES);
	localparam logic [6:0] ATT_LEN =
		7'((ATTITUDE_FRAME_BYTES > isfd_pkg::MAX_LEN) ?
			isfd_pkg::MAX_LEN : ATTITUDE_FRAME_BYTES);
	localparam int unsigned AW = isfd_pkg::STORE_AW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD_TYPE, ST_RD_LEN, ST_RD_END, ST_CHK, ST_GATHER, ST_EMIT
	} state_t;

	state_t state_q;
	isfd_pkg::byte_t regs_q [isfd_pkg::NUM_REGS];
	isfd_pkg::byte_t prev_q, prev2_q;
	logic [7:0] count_q;
	isfd_pkg::kind_t kind_q;
	logic ok_q;
	logic [AW-1:0] addr_q;
	logic [2:0] byte_q;
	isfd_pkg::widx_t widx_q;
	logic [31:0] word_q;
	isfd_pkg::byte_t rd_data_q;
	isfd_pkg::byte_t store_mem [isfd_pkg::STORE_DEPTH];
	logic m_tvalid_q, m_tlast_q;
	logic [39:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	logic s_acc, pattern;
	logic [7:0] nx_count;
	isfd_pkg::kind_t nx_kind;
	logic [6:0] nx_len, cur_len, len_m1;
	logic end_in_store, cmp_hit;
	isfd_pkg::byte_t want_type, want_len, cmp_lhs, cmp_ref;
	logic [AW-1:0] rd_addr;
	logic [31:0] word_shift;
	logic word_last;

	function automatic logic [6:0] len_of(input isfd_pkg::kind_t k);
		logic [6:0] l;
		unique case (k)
			isfd_pkg::KIND_ACCEL: l = ACCEL_LEN;
			isfd_pkg::KIND_ATT:   l = ATT_LEN;
			default:              l = FULL_LEN;
		endcase
		return l;
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	assign pattern = (prev2_q == regs_q[isfd_pkg::REG_END[2:0]]) &&
		(prev_q == regs_q[isfd_pkg::REG_HEAD[2:0]]);

	always_comb begin
		nx_kind = kind_q;
		nx_count = 8'd0;
		if (count_q != 8'd0) begin
			nx_count = 8'(count_q + 8'd1);
		end else if (pattern && s_tdata == regs_q[isfd_pkg::REG_TYPE_FULL[2:0]]) begin
			nx_kind = isfd_pkg::KIND_FULL;
			nx_count = 8'd1;
		end else if (pattern && s_tdata == regs_q[isfd_pkg::REG_TYPE_ACCEL[2:0]]) begin
			nx_kind = isfd_pkg::KIND_ACCEL;
			nx_count = 8'd1;
		end else if (pattern && s_tdata == regs_q[isfd_pkg::REG_TYPE_ATT[2:0]]) begin
			nx_kind = isfd_pkg::KIND_ATT;
			nx_count = 8'd1;
		end
		nx_len = len_of(nx_kind);
	end

	always_comb begin
		cur_len = len_of(kind_q);
		len_m1 = 7'(cur_len - 7'd1);
		end_in_store = (len_m1[6] == 1'b0);
		unique case (kind_q)
			isfd_pkg::KIND_ACCEL: begin
				want_type = regs_q[isfd_pkg::REG_TYPE_ACCEL[2:0]];
				want_len = regs_q[isfd_pkg::REG_LEN_ACCEL[2:0]];
			end
			isfd_pkg::KIND_ATT: begin
				want_type = regs_q[isfd_pkg::REG_TYPE_ATT[2:0]];
				want_len = regs_q[isfd_pkg::REG_LEN_ATT[2:0]];
			end
			default: begin
				want_type = regs_q[isfd_pkg::REG_TYPE_FULL[2:0]];
				want_len = regs_q[isfd_pkg::REG_LEN_FULL[2:0]];
			end
		endcase
		cmp_lhs = rd_data_q;
		cmp_ref = regs_q[isfd_pkg::REG_END[2:0]];
		unique case (state_q)
			ST_RD_LEN: cmp_ref = want_type;
			ST_RD_END: cmp_ref = want_len;
			default: begin
				if (!end_in_store) begin
					cmp_lhs = 8'd0;
				end
			end
		endcase
		cmp_hit = (cmp_lhs == cmp_ref);
		unique case (state_q)
			ST_RD_TYPE: rd_addr = AW'(1);
			ST_RD_LEN:  rd_addr = AW'(2);
			ST_RD_END:  rd_addr = len_m1[AW-1:0];
			default:    rd_addr = addr_q;
		endcase
		word_shift = {rd_data_q, word_q[31:8]};
		word_last = (widx_q == 4'(isfd_pkg::words_of_kind(kind_q) - 4'd1));
	end

	always_ff @(posedge clk) begin
		if (s_acc && count_q[7:AW] == '0) begin
			store_mem[count_q[AW-1:0]] <= prev_q;
		end
		rd_data_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= isfd_pkg::REG_RESET;
		end else if (cfg_valid && cfg_ready && cfg_index < 4'(isfd_pkg::NUM_REGS)) begin
			regs_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q <= '0;
			prev2_q <= '0;
			count_q <= '0;
			kind_q <= isfd_pkg::KIND_FULL;
			ok_q <= 1'b0;
			addr_q <= '0;
			byte_q <= '0;
			widx_q <= '0;
			word_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						prev2_q <= prev_q;
						prev_q <= s_tdata;
						kind_q <= nx_kind;
						count_q <= (nx_count > {1'b0, nx_len}) ? 8'd0 : nx_count;
						if (nx_count == {1'b0, nx_len}) begin
							state_q <= ST_RD_TYPE;
						end
					end
				end
				ST_RD_TYPE: begin
					ok_q <= 1'b1;
					state_q <= ST_RD_LEN;
				end
				ST_RD_LEN: begin
					ok_q <= ok_q && cmp_hit;
					state_q <= ST_RD_END;
				end
				ST_RD_END: begin
					ok_q <= ok_q && cmp_hit;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (ok_q && cmp_hit) begin
						count_q <= '0;
						addr_q <= AW'(isfd_pkg::PAYLOAD_START);
						byte_q <= '0;
						widx_q <= '0;
						state_q <= ST_GATHER;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_GATHER: begin
					if (byte_q != 3'd0) begin
						word_q <= word_shift;
					end
					if (byte_q == 3'd4) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {4'd0, word_shift, widx_q};
						m_tuser_q <= kind_q;
						m_tlast_q <= word_last;
						state_q <= ST_EMIT;
					end else begin
						addr_q <= AW'(addr_q + AW'(1));
						byte_q <= 3'(byte_q + 3'd1);
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (m_tlast_q) begin
							state_q <= ST_IDLE;
						end else begin
							widx_q <= 4'(widx_q + 4'd1);
							byte_q <= '0;
							state_q <= ST_GATHER;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_intake_while_output: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("byte intake open while an output beat is pending");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= {1'b0, cur_len})
		else $error("byte count passed the frame length");

	a_index_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] < isfd_pkg::words_of_kind(m_tuser)))
		else $error("word index beyond the frame payload");

	a_last_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("intake not reopened after the last word");

endmodule

@@ sim/imu_serial_frame_deframer_core_tb.sv @@
// Self-checking testbench of the serial frame deframer core, with its own frame tracker.
`timescale 1ns / 1ps

module imu_serial_frame_deframer_core_tb;

	localparam int unsigned LEN_FULL = isfd_pkg::FULL_FRAME_BYTES_DEF;
	localparam int unsigned LEN_ACCEL = isfd_pkg::ACCEL_FRAME_BYTES_DEF;
	localparam int unsigned LEN_ATT = isfd_pkg::ATTITUDE_FRAME_BYTES_DEF;
	localparam int unsigned AW = isfd_pkg::STORE_AW;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned TAIL_CYCLES = 120;
	localparam int unsigned TRAFFIC_BYTES = 20;
	localparam logic [3:0] IDX_PAST_LAST = 4'd8;
	localparam logic [3:0] IDX_TOP = 4'd15;

	typedef enum int {FLAW_NONE, FLAW_LENGTH, FLAW_END, FLAW_TYPE} frame_flaw_t;

	typedef struct packed {
		isfd_pkg::kind_t kind;
		isfd_pkg::widx_t idx;
		logic [31:0]     word;
		logic            last;
	} word_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	isfd_pkg::byte_t setting [isfd_pkg::NUM_REGS] = isfd_pkg::REG_RESET;
	isfd_pkg::byte_t frame_copy [isfd_pkg::STORE_DEPTH] = '{default: 8'h00};
	isfd_pkg::byte_t last_b = 8'h00;
	isfd_pkg::byte_t older_b = 8'h00;
	int unsigned     frame_fill = 0;
	isfd_pkg::kind_t cur_kind = isfd_pkg::KIND_FULL;

	word_beat_t      words_due [$];
	isfd_pkg::byte_t bytes_in [$];
	int unsigned     bytes_queued = 0;
	int unsigned     bytes_taken = 0;
	int unsigned     beats_checked = 0;
	int unsigned     frames_good [3] = '{0, 0, 0};
	int unsigned     frames_bad = 0;
	int unsigned     settings_used = 1;
	int unsigned     errors = 0;

	logic        calm = 1'b0;
	logic        hold_req = 1'b0;
	logic        hold_taken;
	int unsigned hold_left;
	int unsigned stall_left;
	int unsigned send_gap;

	imu_serial_frame_deframer_core #(
		.FULL_FRAME_BYTES(LEN_FULL),
		.ACCEL_FRAME_BYTES(LEN_ACCEL),
		.ATTITUDE_FRAME_BYTES(LEN_ATT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial forever #1 clk = ~clk;

	function automatic isfd_pkg::byte_t reg_val(input logic [3:0] idx);
		return setting[idx[2:0]];
	endfunction

	function automatic int unsigned frame_bytes(input isfd_pkg::kind_t k);
		case (k)
			isfd_pkg::KIND_ACCEL: return LEN_ACCEL;
			isfd_pkg::KIND_ATT:   return LEN_ATT;
			default:              return LEN_FULL;
		endcase
	endfunction

	function automatic int unsigned payload_words(input isfd_pkg::kind_t k);
		case (k)
			isfd_pkg::KIND_ACCEL: return 4;
			isfd_pkg::KIND_ATT:   return 11;
			default:              return 13;
		endcase
	endfunction

	function automatic isfd_pkg::byte_t type_of(input isfd_pkg::kind_t k);
		case (k)
			isfd_pkg::KIND_ACCEL: return reg_val(isfd_pkg::REG_TYPE_ACCEL);
			isfd_pkg::KIND_ATT:   return reg_val(isfd_pkg::REG_TYPE_ATT);
			default:              return reg_val(isfd_pkg::REG_TYPE_FULL);
		endcase
	endfunction

	function automatic isfd_pkg::byte_t length_of(input isfd_pkg::kind_t k);
		case (k)
			isfd_pkg::KIND_ACCEL: return reg_val(isfd_pkg::REG_LEN_ACCEL);
			isfd_pkg::KIND_ATT:   return reg_val(isfd_pkg::REG_LEN_ATT);
			default:              return reg_val(isfd_pkg::REG_LEN_FULL);
		endcase
	endfunction

	function automatic isfd_pkg::byte_t copy_at(input int unsigned i);
		return (i < isfd_pkg::STORE_DEPTH) ? frame_copy[i[AW-1:0]] : 8'h00;
	endfunction

	function automatic void apply_setting(input logic [3:0] idx, input isfd_pkg::byte_t val);
		if (idx < 4'(isfd_pkg::NUM_REGS))
			setting[idx[2:0]] = val;
	endfunction

	// Tracks one received byte and queues the payload words of a frame that passes its check.
	function automatic void deframe_byte(input isfd_pkg::byte_t b);
		int unsigned cnt;
		int unsigned len;
		int unsigned nw;
		logic        at_start;
		word_beat_t  beat;
		cnt = frame_fill;
		if (cnt < isfd_pkg::STORE_DEPTH)
			frame_copy[cnt[AW-1:0]] = last_b;
		at_start = (older_b == reg_val(isfd_pkg::REG_END)) &&
			(last_b == reg_val(isfd_pkg::REG_HEAD));
		if (cnt > 0) begin
			cnt++;
		end else if (at_start && b == reg_val(isfd_pkg::REG_TYPE_FULL)) begin
			cur_kind = isfd_pkg::KIND_FULL;
			cnt = 1;
		end else if (at_start && b == reg_val(isfd_pkg::REG_TYPE_ACCEL)) begin
			cur_kind = isfd_pkg::KIND_ACCEL;
			cnt = 1;
		end else if (at_start && b == reg_val(isfd_pkg::REG_TYPE_ATT)) begin
			cur_kind = isfd_pkg::KIND_ATT;
			cnt = 1;
		end
		older_b = last_b;
		last_b = b;
		len = frame_bytes(cur_kind);
		if (cnt == len) begin
			if (copy_at(1) == type_of(cur_kind) && copy_at(2) == length_of(cur_kind) &&
					copy_at(len - 1) == reg_val(isfd_pkg::REG_END)) begin
				nw = payload_words(cur_kind);
				for (int unsigned w = 0; w < nw; w++) begin
					beat.kind = cur_kind;
					beat.idx = 4'(w);
					beat.word = {copy_at(isfd_pkg::PAYLOAD_START + 4 * w + 3),
						copy_at(isfd_pkg::PAYLOAD_START + 4 * w + 2),
						copy_at(isfd_pkg::PAYLOAD_START + 4 * w + 1),
						copy_at(isfd_pkg::PAYLOAD_START + 4 * w)};
					beat.last = (w + 1 == nw);
					words_due.push_back(beat);
				end
				frames_good[cur_kind]++;
				cnt = 0;
			end else begin
				frames_bad++;
			end
		end
		if (cnt > len)
			cnt = 0;
		frame_fill = cnt & 32'h7F;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (bytes_in.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= bytes_in.pop_front();
				if (!calm && $urandom_range(0, 99) < 25)
					send_gap <= $urandom_range(1, 10);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 20) begin
			stall_left <= $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			deframe_byte(s_tdata);
			bytes_taken++;
		end
	end

	always @(posedge clk) begin : check_words
		word_beat_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (words_due.size() == 0) begin
				report_mismatch("beat with nothing expected", m_tdata[35:4], 32'h0);
			end else begin
				due = words_due.pop_front();
				beats_checked++;
				if (m_tuser != due.kind)
					report_mismatch("frame_kind", 32'(m_tuser), 32'(due.kind));
				if (m_tdata[3:0] != due.idx)
					report_mismatch("word_index", 32'(m_tdata[3:0]), 32'(due.idx));
				if (m_tdata[35:4] != due.word)
					report_mismatch("payload_word", m_tdata[35:4], due.word);
				if (m_tlast != due.last)
					report_mismatch("last_word", 32'(m_tlast), 32'(due.last));
				if (m_tdata[39:36] != 4'h0)
					report_mismatch("tdata zero fill", 32'(m_tdata[39:36]), 32'h0);
			end
		end
	end

	task automatic queue_byte(input isfd_pkg::byte_t b);
		bytes_in.push_back(b);
		bytes_queued++;
	endtask

	task automatic queue_frame(input isfd_pkg::kind_t k, input frame_flaw_t flaw);
		int unsigned     n;
		isfd_pkg::byte_t fb;
		isfd_pkg::kind_t other;
		n = frame_bytes(k);
		other = (k == isfd_pkg::KIND_ATT) ? isfd_pkg::KIND_FULL : isfd_pkg::kind_t'(k + 1);
		for (int unsigned i = 0; i < n; i++) begin
			if (i == 0)
				fb = reg_val(isfd_pkg::REG_HEAD);
			else if (i == 1)
				fb = (flaw == FLAW_TYPE) ? type_of(other) : type_of(k);
			else if (i == 2)
				fb = length_of(k) ^ ((flaw == FLAW_LENGTH) ? 8'($urandom_range(1, 255)) : 8'h00);
			else if (i == n - 1)
				fb = reg_val(isfd_pkg::REG_END) ^
					((flaw == FLAW_END) ? 8'($urandom_range(1, 255)) : 8'h00);
			else
				fb = 8'($urandom_range(0, 255));
			queue_byte(fb);
		end
	endtask

	// An accelerometer frame with extreme payload values and a start pattern inside it.
	task automatic queue_directed();
		isfd_pkg::byte_t seq [25];
		seq = '{reg_val(isfd_pkg::REG_END), reg_val(isfd_pkg::REG_HEAD),
			reg_val(isfd_pkg::REG_TYPE_ACCEL), reg_val(isfd_pkg::REG_LEN_ACCEL),
			8'h00, 8'hFF, 8'h0F, 8'hF0,
			8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			reg_val(isfd_pkg::REG_END), reg_val(isfd_pkg::REG_HEAD),
			reg_val(isfd_pkg::REG_TYPE_ACCEL), 8'h80,
			8'h01, 8'h7F, 8'hFE, 8'h55, reg_val(isfd_pkg::REG_END)};
		foreach (seq[i])
			queue_byte(seq[i]);
	endtask

	// Mostly well-formed frames with random content, mixed with broken frames and noise.
	task automatic queue_traffic(input int unsigned target, input logic lead_bad_full);
		int unsigned start;
		int unsigned r;
		frame_flaw_t flaw;
		start = bytes_queued;
		queue_byte(reg_val(isfd_pkg::REG_END));
		if (lead_bad_full) begin
			queue_frame(isfd_pkg::KIND_FULL, FLAW_END);
			queue_byte(8'($urandom_range(0, 255)));
			queue_byte(8'($urandom_range(0, 255)));
			queue_byte(reg_val(isfd_pkg::REG_END));
		end
		while (bytes_queued - start < target) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				repeat ($urandom_range(1, 8))
					queue_byte(8'($urandom_range(0, 255)));
				queue_byte(reg_val(isfd_pkg::REG_END));
			end else begin
				flaw = (r < 32) ? frame_flaw_t'($urandom_range(1, 3)) : FLAW_NONE;
				queue_frame(isfd_pkg::kind_t'($urandom_range(0, 2)), flaw);
				if (flaw != FLAW_NONE) begin
					queue_byte(8'($urandom_range(0, 255)));
					queue_byte(8'($urandom_range(0, 255)));
					queue_byte(reg_val(isfd_pkg::REG_END));
				end
			end
		end
	endtask

	// Waits for all beats and words, then pads with bytes until no frame is open.
	task automatic wait_idle();
		do begin
			while (bytes_taken != bytes_queued || words_due.size() != 0)
				@(posedge clk);
			if (frame_fill != 0)
				queue_byte(8'($urandom_range(0, 255)));
		end while (frame_fill != 0 || bytes_taken != bytes_queued);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input logic [3:0] idx, input isfd_pkg::byte_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_setting(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input isfd_pkg::byte_t head, input isfd_pkg::byte_t tail,
			input isfd_pkg::byte_t t_full, input isfd_pkg::byte_t t_accel,
			input isfd_pkg::byte_t t_att, input isfd_pkg::byte_t l_full,
			input isfd_pkg::byte_t l_accel, input isfd_pkg::byte_t l_att);
		write_setting(isfd_pkg::REG_HEAD, head);
		write_setting(isfd_pkg::REG_END, tail);
		write_setting(isfd_pkg::REG_TYPE_FULL, t_full);
		write_setting(isfd_pkg::REG_TYPE_ACCEL, t_accel);
		write_setting(isfd_pkg::REG_TYPE_ATT, t_att);
		write_setting(isfd_pkg::REG_LEN_FULL, l_full);
		write_setting(isfd_pkg::REG_LEN_ACCEL, l_accel);
		write_setting(isfd_pkg::REG_LEN_ATT, l_att);
		settings_used++;
	endtask

	task automatic write_defaults();
		for (int unsigned i = 0; i < isfd_pkg::NUM_REGS; i++)
			write_setting(4'(i), isfd_pkg::REG_RESET[3'(i)]);
		settings_used++;
	endtask

	initial begin
		isfd_pkg::byte_t h;
		isfd_pkg::byte_t t;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		hold_req = 1'b1;
		queue_directed();
		queue_traffic(TRAFFIC_BYTES, 1'b0);
		wait_idle();

		h = 8'($urandom_range(0, 255));
		t = 8'($urandom_range(0, 255));
		write_all(h, h ^ 8'($urandom_range(1, 255)), t, t + 8'd1 + 8'($urandom_range(0, 100)),
			t + 8'd102 + 8'($urandom_range(0, 100)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		write_setting(IDX_PAST_LAST, 8'h00);
		write_setting(IDX_TOP, 8'hFF);
		queue_traffic(TRAFFIC_BYTES, 1'b1);
		wait_idle();

		write_all(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'h80);
		queue_traffic(TRAFFIC_BYTES, 1'b0);
		wait_idle();

		write_all(8'hFC, 8'hFD, 8'h54, 8'h55, 8'h55, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		queue_traffic(TRAFFIC_BYTES, 1'b0);
		wait_idle();

		write_all(8'h5A, 8'hA5, 8'hAA, 8'hAA, 8'hAA, 8'h38, 8'h10, 8'h30);
		queue_traffic(TRAFFIC_BYTES, 1'b0);
		wait_idle();

		calm = 1'b1;
		write_defaults();
		queue_traffic(TRAFFIC_BYTES, 1'b0);
		wait_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d serial bytes under %0d register settings, checked %0d payload words.",
			bytes_taken, settings_used, beats_checked);
		$display("Frames passed: full %0d, accel %0d, attitude %0d; frames rejected: %0d.",
			frames_good[isfd_pkg::KIND_FULL], frames_good[isfd_pkg::KIND_ACCEL],
			frames_good[isfd_pkg::KIND_ATT], frames_bad);
		if (errors == 0) begin
			$display("[imu_serial_frame_deframer_core] OK");
		end else begin
			$display("[imu_serial_frame_deframer_core] ERROR");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("[imu_serial_frame_deframer_core] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/isfd_pkg.sv
rtl/imu_serial_frame_deframer_core.sv
sim/imu_serial_frame_deframer_core_tb.sv
